// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== rtl/core/asbb_pkg.sv =====
`default_nettype none

package asbb_pkg;

  localparam int DEF_COORD_WIDTH     = 32;
  localparam int DEF_ANGLE_FRAC_BITS = 24;
  localparam int DEF_CORDIC_STAGES   = 24;

  // Bearings travel as 32-bit fields whatever the fraction width
  localparam int BEARING_W = 32;

  // CORDIC datapath width, two guard bits over Q1.30 plus sign
  localparam int CRD_W = 34;

  // 0.60725 in Q1.30
  localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;

  // arctan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;  15: v = 32'h0000517C;
      16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A2F;  19: v = 32'h00000517;
      20: v = 32'h0000028B;  21: v = 32'h00000145;
      22: v = 32'h000000A2;  23: v = 32'h00000051;
      24: v = 32'h00000028;  25: v = 32'h00000014;
      26: v = 32'h0000000A;  27: v = 32'h00000005;
      28: v = 32'h00000002;  29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/annular_sector_bounding_box_unit.sv =====
// Axis-aligned bounding box of an annular sector. One sector is taken per clock while the
// skid register is empty, and one box comes out per sector, in order. The stages are the input
// register, bearing preparation, the CORDIC_STAGES unrolled CORDIC stages (one lane per
// bearing), sign/magnitude, multiply, place-and-saturate, two min/max stages and the output
// register. A skid register decouples the sides: input keeps flowing during an output stall
// until a box reaches the skid register, and in_tready stays low for as long as the skid
// holds a box. A sector with broken radius or bearing rules returns an all-zero box with
// out_tuser set.
`default_nettype none
`include "assert_macros.svh"

module annular_sector_bounding_box_unit
  import asbb_pkg::*;
#(
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES,
  localparam int IN_W  = ((4*COORD_WIDTH + 2*BEARING_W + 7) / 8) * 8,
  localparam int OUT_W = ((4*COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // center_x, center_y, outer_radius, inner_radius, start_bearing, end_bearing
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // box_min_x, box_min_y, box_max_x, box_max_y
  output logic [OUT_W-1:0]      out_tdata,
  // params_invalid
  output logic                  out_tuser
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = CRD_W;
  localparam int EW = 34;                 // extended bearing width
  localparam int PW = CW - 1 + 32;        // radius magnitude times trig magnitude
  localparam int MW = PW - 29;            // rounded offset magnitude
  localparam int SW = CW + 3;             // centre plus offset before saturation
  localparam int NS = CORDIC_STAGES;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] ro;
    logic signed [CW-1:0] ri;
    logic                 inv;
    logic [3:0]           card;   // north, east, south, west in span
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] mnx;
    logic signed [CW-1:0] mny;
    logic signed [CW-1:0] mxx;
    logic signed [CW-1:0] mxy;
    logic                 inv;
  } box_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'((SW'(1) <<< (CW-1)) - SW'(1));
    lo = -hi - SW'(1);
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] mn(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] mx(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic en;
  logic skid_v_r;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // ---------------- input register
  logic            v1_r;
  logic [IN_W-1:0] d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) d1_r <= in_tdata;
  end

  // ---------------- bearing preparation
  logic signed [CW-1:0]        f_cx, f_cy, f_ro, f_ri;
  logic signed [BEARING_W-1:0] f_sb, f_eb;
  logic [ANGLE_FRAC_BITS-1:0]  s_frac;
  logic [EW-1:0]               span, e_ext, s_ext;
  logic [31:0]                 ts, te;
  side_t                       side2_nxt;

  assign f_cx = d1_r[CW-1:0];
  assign f_cy = d1_r[2*CW-1:CW];
  assign f_ro = d1_r[3*CW-1:2*CW];
  assign f_ri = d1_r[4*CW-1:3*CW];
  assign f_sb = d1_r[4*CW+BEARING_W-1:4*CW];
  assign f_eb = d1_r[4*CW+2*BEARING_W-1:4*CW+BEARING_W];

  assign s_frac = f_sb[ANGLE_FRAC_BITS-1:0];
  assign s_ext  = EW'(s_frac);
  assign span   = EW'($signed({f_eb[BEARING_W-1], f_eb}) - $signed({f_sb[BEARING_W-1], f_sb}));
  assign e_ext  = s_ext + span;
  assign ts     = 32'(s_ext) << (32 - ANGLE_FRAC_BITS);
  assign te     = 32'(e_ext[ANGLE_FRAC_BITS-1:0]) << (32 - ANGLE_FRAC_BITS);

  always_comb begin
    logic [EW-1:0] cand;
    side2_nxt.cx  = f_cx;
    side2_nxt.cy  = f_cy;
    side2_nxt.ro  = f_ro;
    side2_nxt.ri  = f_ri;
    side2_nxt.inv = (f_ro <= 0) || (f_ri < 0) || (f_ro <= f_ri) || (f_sb >= f_eb);
    for (int q = 0; q < 4; q++) begin
      cand = EW'(q) << (ANGLE_FRAC_BITS - 2);
      if (cand < s_ext) cand = cand + (EW'(1) << ANGLE_FRAC_BITS);
      side2_nxt.card[q] = (cand <= e_ext);
    end
  end

  // ---------------- CORDIC, index 0 is the prepared stage, lane 0 start, lane 1 end
  logic                 cv_r   [0:NS];
  side_t                cs_r   [0:NS];
  logic signed [AW-1:0] cx_r   [0:NS][0:1];
  logic signed [AW-1:0] cy_r   [0:NS][0:1];
  logic signed [AW-1:0] cz_r   [0:NS][0:1];
  logic                 flip_r [0:NS][0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (en) cv_r[0] <= v1_r;
  end

  for (genvar j = 0; j < 2; j++) begin : g_init
    logic [31:0] u, uf;
    logic        fl;
    assign u  = (j == 0) ? ts : te;
    assign fl = u[31] ^ u[30];            // bearing in [1/4, 3/4) turn
    assign uf = fl ? (u + 32'h80000000) : u;
    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[0][j]   <= GAIN_Q30;
        cy_r[0][j]   <= '0;
        cz_r[0][j]   <= AW'($signed(uf));
        flip_r[0][j] <= fl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) cs_r[0] <= side2_nxt;
  end

  for (genvar k = 0; k < NS; k++) begin : g_crd
    localparam logic signed [AW-1:0] ATAN = AW'(atan_turn(k));
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[k+1] <= 1'b0;
      else if (en) cv_r[k+1] <= cv_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) cs_r[k+1] <= cs_r[k];
    end
    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic signed [AW-1:0] xs, ys;
      assign xs = cx_r[k][j] >>> k;
      assign ys = cy_r[k][j] >>> k;
      always_ff @(posedge clk) begin
        if (en) begin
          flip_r[k+1][j] <= flip_r[k][j];
          if (cz_r[k][j] >= 0) begin
            cx_r[k+1][j] <= cx_r[k][j] - ys;
            cy_r[k+1][j] <= cy_r[k][j] + xs;
            cz_r[k+1][j] <= cz_r[k][j] - ATAN;
          end else begin
            cx_r[k+1][j] <= cx_r[k][j] + ys;
            cy_r[k+1][j] <= cy_r[k][j] - xs;
            cz_r[k+1][j] <= cz_r[k][j] + ATAN;
          end
        end
      end
    end
  end

  // ---------------- sign and magnitude of sin, cos; lane j, axis a (0 sin, 1 cos)
  logic        v3_r;
  side_t       sd3_r;
  logic [31:0] mag3_r [0:1][0:1];
  logic        neg3_r [0:1][0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= cv_r[NS];
  end

  always_ff @(posedge clk) begin
    if (en) sd3_r <= cs_r[NS];
  end

  for (genvar j = 0; j < 2; j++) begin : g_mag
    for (genvar a = 0; a < 2; a++) begin : g_ax
      logic signed [AW-1:0] raw, t;
      assign raw = (a == 0) ? cy_r[NS][j] : cx_r[NS][j];
      assign t   = flip_r[NS][j] ? -raw : raw;
      always_ff @(posedge clk) begin
        if (en) begin
          neg3_r[j][a] <= t[AW-1];
          mag3_r[j][a] <= t[AW-1] ? 32'(-t) : 32'(t);
        end
      end
    end
  end

  // ---------------- products; radius r (0 outer, 1 inner)
  logic          v4_r;
  side_t         sd4_r;
  logic [PW-1:0] prod4_r [0:1][0:1][0:1];
  logic          neg4_r  [0:1][0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r  <= sd3_r;
      neg4_r <= neg3_r;
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_mul
    for (genvar r = 0; r < 2; r++) begin : g_rad
      for (genvar a = 0; a < 2; a++) begin : g_ax
        logic [CW-2:0] rm;
        assign rm = (r == 0) ? sd3_r.ro[CW-2:0] : sd3_r.ri[CW-2:0];
        always_ff @(posedge clk) begin
          if (en) prod4_r[j][r][a] <= PW'(rm) * PW'(mag3_r[j][a]);
        end
      end
    end
  end

  // ---------------- place and saturate points
  logic                 v5_r;
  side_t                sd5_r;
  logic signed [CW-1:0] px5_r [0:3];
  logic signed [CW-1:0] py5_r [0:3];
  logic signed [CW-1:0] xe5_r, xw5_r, yn5_r, ys5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  for (genvar j = 0; j < 2; j++) begin : g_pt
    for (genvar r = 0; r < 2; r++) begin : g_rad
      logic [PW:0]          rnd_x, rnd_y;
      logic [MW-1:0]        mgx, mgy;
      logic signed [SW-1:0] ox, oy;
      assign rnd_x = {1'b0, prod4_r[j][r][0]} + ((PW+1)'(1) << 29);
      assign rnd_y = {1'b0, prod4_r[j][r][1]} + ((PW+1)'(1) << 29);
      assign mgx   = rnd_x[PW:30];
      assign mgy   = rnd_y[PW:30];
      assign ox    = neg4_r[j][0] ? -$signed(SW'(mgx)) : $signed(SW'(mgx));
      assign oy    = neg4_r[j][1] ? -$signed(SW'(mgy)) : $signed(SW'(mgy));
      always_ff @(posedge clk) begin
        if (en) begin
          px5_r[2*r+j] <= sat(SW'(sd4_r.cx) + ox);
          py5_r[2*r+j] <= sat(SW'(sd4_r.cy) + oy);
        end
      end
    end
  end

  // Inner cardinals never reach past the outer ones, so only the outer arc counts
  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r <= sd4_r;
      yn5_r <= sd4_r.card[0] ? sat(SW'(sd4_r.cy) + SW'(sd4_r.ro)) : sd4_r.cy;
      xe5_r <= sd4_r.card[1] ? sat(SW'(sd4_r.cx) + SW'(sd4_r.ro)) : sd4_r.cx;
      ys5_r <= sd4_r.card[2] ? sat(SW'(sd4_r.cy) - SW'(sd4_r.ro)) : sd4_r.cy;
      xw5_r <= sd4_r.card[3] ? sat(SW'(sd4_r.cx) - SW'(sd4_r.ro)) : sd4_r.cx;
    end
  end

  // ---------------- min/max, first half
  logic                 v6_r;
  logic                 inv6_r;
  logic signed [CW-1:0] mnx6_r [0:1];
  logic signed [CW-1:0] mny6_r [0:1];
  logic signed [CW-1:0] mxx6_r [0:1];
  logic signed [CW-1:0] mxy6_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv6_r    <= sd5_r.inv;
      mnx6_r[0] <= mn(sd5_r.cx, mn(px5_r[0], px5_r[1]));
      mnx6_r[1] <= mn(xw5_r, mn(px5_r[2], px5_r[3]));
      mxx6_r[0] <= mx(sd5_r.cx, mx(px5_r[0], px5_r[1]));
      mxx6_r[1] <= mx(xe5_r, mx(px5_r[2], px5_r[3]));
      mny6_r[0] <= mn(sd5_r.cy, mn(py5_r[0], py5_r[1]));
      mny6_r[1] <= mn(ys5_r, mn(py5_r[2], py5_r[3]));
      mxy6_r[0] <= mx(sd5_r.cy, mx(py5_r[0], py5_r[1]));
      mxy6_r[1] <= mx(yn5_r, mx(py5_r[2], py5_r[3]));
    end
  end

  // ---------------- min/max, final
  logic v7_r;
  box_t b7_r;
  box_t b7_nxt;

  always_comb begin
    b7_nxt.inv = inv6_r;
    if (inv6_r) begin
      b7_nxt.mnx = '0;
      b7_nxt.mny = '0;
      b7_nxt.mxx = '0;
      b7_nxt.mxy = '0;
    end else begin
      b7_nxt.mnx = mn(mnx6_r[0], mnx6_r[1]);
      b7_nxt.mny = mn(mny6_r[0], mny6_r[1]);
      b7_nxt.mxx = mx(mxx6_r[0], mxx6_r[1]);
      b7_nxt.mxy = mx(mxy6_r[0], mxy6_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (en) b7_r <= b7_nxt;
  end

  // ---------------- output register and skid
  logic out_v_r;
  box_t out_b_r;
  box_t skid_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      out_v_r  <= skid_v_r || v7_r;
      skid_v_r <= 1'b0;
    end else if (en && v7_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_b_r <= skid_v_r ? skid_b_r : b7_r;
    end else if (en && v7_r) begin
      skid_b_r <= b7_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_b_r.inv;
  assign out_tdata  = OUT_W'({out_b_r.mxy, out_b_r.mxx, out_b_r.mny, out_b_r.mnx});

  // ---------------- checks
  `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_v_r |-> out_v_r,
               "skid holds a transfer while the output register is empty")
  `ASSERT_IMPL(a_skid_drains, clk, rst_n, (skid_v_r && out_tready) |=> !skid_v_r,
               "skid not drained after output transfer")
  `ASSERT_IMPL(a_invalid_zero, clk, rst_n,
               (out_v_r && out_b_r.inv) |-> (out_b_r.mnx == 0 && out_b_r.mxy == 0),
               "invalid sector with non-zero box")
  `ASSERT_IMPL(a_box_ordered, clk, rst_n,
               (out_v_r && !out_b_r.inv) |-> (out_b_r.mnx <= out_b_r.mxx &&
                                              out_b_r.mny <= out_b_r.mxy),
               "box minimum above maximum")

endmodule

`default_nettype wire
